FILE: rtl/core/bfc_pkg.sv
// Brick frustum cull package: widths, register map and shared types.
// Used by every module of the brick frustum cull test; depends on nothing.
`default_nettype none

package bfc_pkg;

    // Grid and plane counts
    localparam int NUM_LEVELS = 16;
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;

    // Field widths
    localparam int LVL_W   = 4;
    localparam int COORD_W = 17;
    localparam int CDIM_W  = 11;
    localparam int EXT_W   = 18;
    localparam int NRM_W   = 12;
    localparam int OFS_W   = 28;

    // Derived datapath widths: brick size, lower bound, product, plane sum
    localparam int SIZE_W = CDIM_W + NUM_LEVELS - 1;
    localparam int LO_W   = COORD_W + SIZE_W;
    localparam int PROD_W = NRM_W + LO_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(NUM_LEVELS - 1);

    // Configuration port
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [IDX_W-1:0] REG_PLANE_FAR    = 3'd5;
    localparam logic [IDX_W-1:0] REG_CHUNK_DIM    = 3'd6;
    localparam logic [IDX_W-1:0] REG_VOL_EXTENT   = 3'd7;

    localparam logic [CDIM_W-1:0] CHUNK_DIM_RST = 11'd64;

    // One clip plane as packed in its register
    typedef struct packed {
        logic signed [OFS_W-1:0] ofs;
        logic signed [NRM_W-1:0] nz;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nx;
    } t_plane;

    typedef t_plane [NUM_PLANES-1:0] t_plane_set;

    // Voxel bounds of one brick, axis 0 = x, 1 = y, 2 = z
    typedef struct packed {
        logic [NUM_AXES-1:0][LO_W-1:0]  lo;
        logic [NUM_AXES-1:0][EXT_W-1:0] hi;
    } t_box;

endpackage

`default_nettype wire

FILE: rtl/core/brick_frustum_cull_test.sv
// Brick frustum cull test, top level: register file, bounds and plane pipelines.
// Depends on bfc_pkg, bfc_regs, bfc_bounds and bfc_planes.
//
// Takes one brick request per clock cycle and never stalls: busy stays low.
// Each request gives one result six cycles later: o_done is high for one
// cycle with o_in_frustum, in request order, and the receiver must take it
// then. The latency is set by six register stages (brick size, lower corner
// multiply, upper corner clip, per-plane multiplies, plane sums, verdict).
// Plane registers sit at byte address 8*i (left, right, bottom, top, near,
// far), then chunk_dim and volume_extent; write them only while no request
// is in flight. After reset all planes are zero and every brick is kept.
`default_nettype none

module brick_frustum_cull_test
    import bfc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [LVL_W-1:0]   i_brick_level,
    input  wire logic [COORD_W-1:0] i_brick_z,
    input  wire logic [COORD_W-1:0] i_brick_y,
    input  wire logic [COORD_W-1:0] i_brick_x,
    output logic                    o_done,
    output logic                    o_in_frustum,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready
);

    t_plane_set                       planes;
    logic [CDIM_W-1:0]                chunk_dim;
    logic [NUM_AXES*EXT_W-1:0]        extent;
    logic [NUM_AXES-1:0][COORD_W-1:0] coord;
    logic                             box_valid;
    t_box                             box;
    logic                             req;

    // Accept a request whenever start is high
    assign busy  = 1'b0;
    assign req   = start & ~busy;
    assign coord = {i_brick_z, i_brick_y, i_brick_x};

    bfc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_planes    (planes),
        .o_chunk_dim (chunk_dim),
        .o_extent    (extent)
    );

    bfc_bounds u_bounds (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (req),
        .i_level     (i_brick_level),
        .i_coord     (coord),
        .i_chunk_dim (chunk_dim),
        .i_extent    (extent),
        .o_valid     (box_valid),
        .o_box       (box)
    );

    bfc_planes u_planes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (box_valid),
        .i_box    (box),
        .i_planes (planes),
        .o_valid  (o_done),
        .o_inside (o_in_frustum)
    );

endmodule

`default_nettype wire

FILE: rtl/core/bfc_regs.sv
// Configuration register file: clip planes, chunk dimension, volume extent.
// APB-style write and read access; depends on bfc_pkg.
`default_nettype none

module bfc_regs
    import bfc_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ADDR_W-1:0]            paddr,
    input  wire logic [DATA_W-1:0]            pwdata,
    output logic      [DATA_W-1:0]            prdata,
    output logic                              pready,
    output t_plane_set                        o_planes,
    output logic      [CDIM_W-1:0]            o_chunk_dim,
    output logic      [NUM_AXES*EXT_W-1:0]    o_extent
);

    t_plane_set                      r_planes;
    logic [CDIM_W-1:0]               r_chunk_dim;
    logic [NUM_AXES*EXT_W-1:0]       r_extent;
    logic [IDX_W-1:0]                idx;
    logic                            wr_en;

    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Write the addressed register at the end of the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes    <= '0;
            r_chunk_dim <= CHUNK_DIM_RST;
            r_extent    <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_PLANE_LEFT,
                REG_PLANE_RIGHT,
                REG_PLANE_BOTTOM,
                REG_PLANE_TOP,
                REG_PLANE_NEAR,
                REG_PLANE_FAR: begin
                    r_planes[idx] <= pwdata;
                end
                REG_CHUNK_DIM: begin
                    r_chunk_dim <= pwdata[CDIM_W-1:0];
                end
                REG_VOL_EXTENT: begin
                    r_extent <= pwdata[NUM_AXES*EXT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        case (idx)
            REG_PLANE_LEFT,
            REG_PLANE_RIGHT,
            REG_PLANE_BOTTOM,
            REG_PLANE_TOP,
            REG_PLANE_NEAR,
            REG_PLANE_FAR: prdata = r_planes[idx];
            REG_CHUNK_DIM:  prdata = DATA_W'(r_chunk_dim);
            REG_VOL_EXTENT: prdata = DATA_W'(r_extent);
            default:        prdata = '0;
        endcase
    end

    assign o_planes    = r_planes;
    assign o_chunk_dim = r_chunk_dim;
    assign o_extent    = r_extent;

endmodule

`default_nettype wire

FILE: rtl/core/bfc_bounds.sv
// Brick bounds pipeline: brick size, lower corner, clipped upper corner.
// Three register stages; depends on bfc_pkg.
`default_nettype none

module bfc_bounds
    import bfc_pkg::*;
(
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic [LVL_W-1:0]                     i_level,
    input  wire logic [NUM_AXES-1:0][COORD_W-1:0]     i_coord,
    input  wire logic [CDIM_W-1:0]                    i_chunk_dim,
    input  wire logic [NUM_AXES*EXT_W-1:0]            i_extent,
    output logic                                      o_valid,
    output t_box                                      o_box
);

    logic                             r_a_valid;
    logic [SIZE_W-1:0]                r_a_size;
    logic [NUM_AXES-1:0][COORD_W-1:0] r_a_coord;
    logic                             r_b_valid;
    logic [SIZE_W-1:0]                r_b_size;
    logic [NUM_AXES-1:0][LO_W-1:0]    r_b_lo;
    logic                             r_c_valid;
    t_box                             r_c_box;
    logic [LVL_W-1:0]                 lvl;
    logic [NUM_AXES-1:0][EXT_W-1:0]   n_hi;

    // Clamp the level to the deepest one supported
    assign lvl = (i_level > LVL_MAX) ? LVL_MAX : i_level;

    // Advance valid bits every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Stage A: brick edge length at this level
    always_ff @(posedge i_clk) begin
        r_a_size  <= SIZE_W'(i_chunk_dim) << lvl;
        r_a_coord <= i_coord;
    end

    // Stage B: lower corner per axis
    always_ff @(posedge i_clk) begin
        r_b_size <= r_a_size;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_b_lo[a] <= LO_W'(r_a_coord[a]) * LO_W'(r_a_size);
        end
    end

    // Stage C: upper corner, clipped to the volume extent
    always_comb begin
        logic [LO_W:0]      b1;
        logic [EXT_W-1:0]   ext;
        for (int a = 0; a < NUM_AXES; a++) begin
            ext = i_extent[a*EXT_W +: EXT_W];
            b1  = {1'b0, r_b_lo[a]} + (LO_W+1)'(r_b_size);
            n_hi[a] = (b1 > (LO_W+1)'(ext)) ? ext : b1[EXT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_box.lo <= r_b_lo;
        r_c_box.hi <= n_hi;
    end

    assign o_valid = r_c_valid;
    assign o_box   = r_c_box;

endmodule

`default_nettype wire

FILE: rtl/core/bfc_planes.sv
// Plane test pipeline: far-corner products, plane sums, final verdict.
// Three register stages; depends on bfc_pkg.
`default_nettype none

module bfc_planes
    import bfc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_box          i_box,
    input  wire t_plane_set    i_planes,
    output logic               o_valid,
    output logic               o_inside
);

    logic                      r_d_valid;
    logic signed [PROD_W-1:0]  r_d_prod [NUM_PLANES][NUM_AXES];
    logic                      r_e_valid;
    logic [NUM_PLANES-1:0]     r_e_cull;
    logic                      r_f_valid;
    logic                      r_f_inside;
    logic [NUM_PLANES-1:0]     n_cull;

    function automatic logic signed [NRM_W-1:0] norm_of(input t_plane pl, input int axis);
        logic signed [NRM_W-1:0] n;
        case (axis)
            0:       n = pl.nx;
            1:       n = pl.ny;
            default: n = pl.nz;
        endcase
        return n;
    endfunction

    // Advance valid bits every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_d_valid <= i_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    // Stage D: pick the corner farthest along each normal and multiply
    always_ff @(posedge i_clk) begin
        logic signed [NRM_W-1:0] n;
        logic [LO_W-1:0]         opnd;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                n    = norm_of(i_planes[p], a);
                opnd = n[NRM_W-1] ? i_box.lo[a] : LO_W'(i_box.hi[a]);
                r_d_prod[p][a] <= PROD_W'(n) * $signed({1'b0, opnd});
            end
        end
    end

    // Stage E: add products and offset, flag a negative sum
    always_comb begin
        logic signed [SUM_W-1:0] s;
        for (int p = 0; p < NUM_PLANES; p++) begin
            s = SUM_W'(r_d_prod[p][0]) + SUM_W'(r_d_prod[p][1])
              + SUM_W'(r_d_prod[p][2]) + SUM_W'(i_planes[p].ofs);
            n_cull[p] = s[SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_cull <= n_cull;
    end

    // Stage F: keep the brick unless some plane culls it
    always_ff @(posedge i_clk) begin
        r_f_inside <= ~|r_e_cull;
    end

    assign o_valid  = r_f_valid;
    assign o_inside = r_f_inside;

endmodule

`default_nettype wire

FILE: verif/brick_frustum_cull_test_tb.sv
// Self-checking testbench for brick_frustum_cull_test: box-versus-frustum verdicts
// are predicted per request and compared in order. Depends on bfc_pkg and the RTL.
module brick_frustum_cull_test_tb
    import bfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 10;            // pipeline depth plus margin
    localparam int Q_ONE         = 1024;          // 1.0 in Q1.10
    localparam int NRM_MAX       = 2047;
    localparam int NRM_MIN       = -2048;
    localparam int OFS_MAX       = (1 << 27) - 1;
    localparam int OFS_MIN       = -(1 << 27);
    localparam int EXT_MAX       = (1 << EXT_W) - 1;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int BOUND_CAP     = 131071;        // keeps bound*Q_ONE inside the offset
    localparam longint TIME_LIMIT = 2_000_000;    // ns

    typedef enum {
        CFG_BOX_FIXED, CFG_BOX_RAND, CFG_EXTREME, CFG_ZERO_CHUNK, CFG_RANDOM, CFG_BOX_OPEN
    } t_cfg_kind;

    typedef struct packed {
        logic [LVL_W-1:0]   lvl;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_brick_req;

    typedef struct {
        t_brick_req req;
        logic       keep;
    } t_verdict;

    // DUT connections
    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic [LVL_W-1:0]   i_brick_level = '0;
    logic [COORD_W-1:0] i_brick_z     = '0;
    logic [COORD_W-1:0] i_brick_y     = '0;
    logic [COORD_W-1:0] i_brick_x     = '0;
    logic               o_done;
    logic               o_in_frustum;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]  pwdata        = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Register shadow used by the predictor
    t_plane_set             plane_cfg = '0;
    logic [CDIM_W-1:0]      cdim_cfg  = CHUNK_DIM_RST;
    logic [3*EXT_W-1:0]     ext_cfg   = '0;

    t_brick_req brick_req_q [$];
    t_verdict   verdict_q [$];
    int         send_idle_pct = 0;
    int         n_errors      = 0;
    int         n_checked     = 0;
    int         n_kept        = 0;
    int         n_culled      = 0;
    int         n_settings    = 1;

    brick_frustum_cull_test u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_brick_level (i_brick_level),
        .i_brick_z     (i_brick_z),
        .i_brick_y     (i_brick_y),
        .i_brick_x     (i_brick_x),
        .o_done        (o_done),
        .o_in_frustum  (o_in_frustum),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Box of the brick against every plane: positive-vertex test, exact integers
    function automatic logic brick_visible(t_brick_req b);
        longint           size;
        longint           b0;
        longint           b1;
        longint           acc;
        longint           crd [NUM_AXES];
        longint           lo [NUM_AXES];
        longint           hi [NUM_AXES];
        longint           n [NUM_AXES];
        logic [LVL_W-1:0] lvl;
        t_plane           pl;
        logic             keep;
        int               a;
        int               p;
        lvl = (b.lvl > LVL_MAX) ? LVL_MAX : b.lvl;
        size = longint'(cdim_cfg) << lvl;
        crd[0] = b.x;
        crd[1] = b.y;
        crd[2] = b.z;
        for (a = 0; a < NUM_AXES; a++) begin
            b0 = crd[a] * size;
            b1 = b0 + size;
            if (b1 > longint'(ext_cfg[a*EXT_W +: EXT_W]))
                b1 = longint'(ext_cfg[a*EXT_W +: EXT_W]);
            lo[a] = b0;
            hi[a] = b1;
        end
        keep = 1'b1;
        for (p = 0; p < NUM_PLANES; p++) begin
            pl = plane_cfg[p];
            n[0] = longint'($signed(pl.nx));
            n[1] = longint'($signed(pl.ny));
            n[2] = longint'($signed(pl.nz));
            acc = longint'($signed(pl.ofs));
            for (a = 0; a < NUM_AXES; a++)
                acc += n[a] * ((n[a] >= 0) ? hi[a] : lo[a]);
            if (acc < 0)
                keep = 1'b0;
        end
        return keep;
    endfunction

    function automatic t_plane plane_of(int nx, int ny, int nz, int ofs);
        t_plane pl;
        pl.nx  = NRM_W'(nx);
        pl.ny  = NRM_W'(ny);
        pl.nz  = NRM_W'(nz);
        pl.ofs = OFS_W'(ofs);
        return pl;
    endfunction

    // Plane keeping coordinate >= bound (lower) or <= bound (upper) on one axis
    function automatic t_plane axis_plane(int axis, bit upper, int bound, bit tilt);
        int n [NUM_AXES];
        int a;
        for (a = 0; a < NUM_AXES; a++)
            n[a] = tilt ? int'($urandom_range(128)) - 64 : 0;
        n[axis] += upper ? -Q_ONE : Q_ONE;
        return plane_of(n[0], n[1], n[2], upper ? bound * Q_ONE : -bound * Q_ONE);
    endfunction

    // Mostly bricks in and around the volume, the rest anywhere in the grid
    function automatic t_brick_req make_brick();
        t_brick_req b;
        longint     size;
        longint     span [NUM_AXES];
        int         a;
        if ($urandom_range(3) == 0) begin
            b.lvl = LVL_W'($urandom_range(NUM_LEVELS - 1));
            b.z   = COORD_W'($urandom_range(COORD_MAX));
            b.y   = COORD_W'($urandom_range(COORD_MAX));
            b.x   = COORD_W'($urandom_range(COORD_MAX));
        end else begin
            b.lvl = ($urandom_range(3) == 0) ? LVL_W'($urandom_range(NUM_LEVELS - 1))
                                             : LVL_W'($urandom_range(3));
            size = longint'(cdim_cfg) << b.lvl;
            for (a = 0; a < NUM_AXES; a++) begin
                span[a] = (size == 0) ? COORD_MAX
                                      : longint'(ext_cfg[a*EXT_W +: EXT_W]) / size + 1;
                if (span[a] > COORD_MAX)
                    span[a] = COORD_MAX;
            end
            b.x = COORD_W'($urandom_range(int'(span[0])));
            b.y = COORD_W'($urandom_range(int'(span[1])));
            b.z = COORD_W'($urandom_range(int'(span[2])));
        end
        return b;
    endfunction

    function automatic void push_brick(int lvl, int z, int y, int x);
        t_brick_req b;
        b.lvl = LVL_W'(lvl);
        b.z   = COORD_W'(z);
        b.y   = COORD_W'(y);
        b.x   = COORD_W'(x);
        brick_req_q.insert(brick_req_q.size(), b);
    endfunction

    function automatic void note_error(string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // APB write: setup cycle, access cycle, done on the edge with pready high
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHUNK_DIM:  cdim_cfg = val[CDIM_W-1:0];
            REG_VOL_EXTENT: ext_cfg  = val[3*EXT_W-1:0];
            default:        plane_cfg[idx] = t_plane'(val);
        endcase
    endtask

    // Hold until every request is taken and answered, then let the pipe drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (brick_req_q.size() != 0 || start || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Build one register setting and write all eight registers
    task automatic load_config(input t_cfg_kind kind);
        t_plane_set        pl;
        logic [CDIM_W-1:0] cd;
        logic [EXT_W-1:0]  ex [NUM_AXES];
        logic [DATA_W-1:0] junk;
        int                cap;
        int                lo_b;
        int                hi_b;
        int                a;
        int                p;
        // box window on each axis, as a pair of facing planes
        for (a = 0; a < NUM_AXES; a++) begin
            if (kind == CFG_BOX_FIXED) begin
                ex[a] = EXT_W'(65536);
                lo_b  = 4096;
                hi_b  = 32768;
            end else begin
                ex[a] = EXT_W'($urandom_range(EXT_MAX, 1000));
                cap   = (int'(ex[a]) < BOUND_CAP) ? int'(ex[a]) : BOUND_CAP;
                lo_b  = $urandom_range(cap / 2);
                hi_b  = $urandom_range(cap, lo_b);
            end
            pl[2*a]   = axis_plane(a, 1'b0, lo_b, kind != CFG_BOX_FIXED);
            pl[2*a+1] = axis_plane(a, 1'b1, hi_b, kind != CFG_BOX_FIXED);
        end
        cd   = CHUNK_DIM_RST;
        junk = '0;
        case (kind)
            CFG_BOX_RAND:   cd = CDIM_W'($urandom_range(64, 1));
            CFG_ZERO_CHUNK: cd = '0;
            CFG_BOX_OPEN: begin
                cd = CDIM_W'(1024);
                for (p = 0; p < NUM_PLANES; p++)
                    if ($urandom_range(1) == 1)
                        pl[p] = '0;
            end
            CFG_RANDOM: begin
                cd   = CDIM_W'(1);
                junk = {$urandom, $urandom};
                for (p = 0; p < NUM_PLANES; p++)
                    pl[p] = t_plane'({$urandom, $urandom});
                for (a = 0; a < NUM_AXES; a++)
                    ex[a] = EXT_W'($urandom_range(EXT_MAX));
            end
            CFG_EXTREME: begin
                cd = '1;
                for (a = 0; a < NUM_AXES; a++)
                    ex[a] = '1;
                pl[0] = plane_of(NRM_MAX, NRM_MAX, NRM_MAX, OFS_MIN);
                pl[1] = plane_of(NRM_MIN, NRM_MIN, NRM_MIN, OFS_MAX);
                pl[2] = plane_of(NRM_MAX, NRM_MIN, 0, 0);
                pl[3] = plane_of(NRM_MIN, NRM_MAX, NRM_MAX, OFS_MAX);
                pl[4] = '0;
                pl[5] = plane_of(0, 0, NRM_MAX, -(1 << 25));
            end
            default: ;
        endcase
        for (p = 0; p < NUM_PLANES; p++)
            write_reg(REG_PLANE_LEFT + IDX_W'(p), pl[p]);
        // unused upper bits carry junk in the random setting
        write_reg(REG_CHUNK_DIM, DATA_W'(cd) | (junk & ~DATA_W'({CDIM_W{1'b1}})));
        write_reg(REG_VOL_EXTENT,
                  DATA_W'({ex[2], ex[1], ex[0]}) | (junk & ~DATA_W'({3*EXT_W{1'b1}})));
        n_settings++;
    endtask

    task automatic run_phase(input t_cfg_kind kind, input int idle_pct, input int count);
        load_config(kind);
        send_idle_pct = idle_pct;
        if (kind == CFG_BOX_FIXED) begin
            // window is [4096, 32768] on every axis, extent 65536, chunk 64
            push_brick(0, 100, 100, 100);
            push_brick(0, 100, 100, 0);
            push_brick(0, 100, 100, 1000);
            push_brick(0, 100, 0, 100);
            push_brick(0, 100, 1000, 100);
            push_brick(0, 0, 100, 100);
            push_brick(0, 1000, 100, 100);
            push_brick(0, 100, 100, 63);      // upper face touches the left plane
            push_brick(0, 100, 100, 62);      // one brick short of it
            push_brick(0, 100, 100, 1100);    // past the volume, upper bound clipped
            push_brick(15, 0, 0, 0);
            push_brick(15, 1, 1, 1);          // clipped upper below lower bound
            push_brick(15, COORD_MAX, COORD_MAX, COORD_MAX);
            push_brick(9, 0, 0, 1);           // plane sum exactly zero on the right
        end
        repeat (count)
            brick_req_q.insert(brick_req_q.size(), make_brick());
        wait_idle();
    endtask

    // Driver: advance to the next request once the current one is taken
    always @(posedge i_clk) begin
        t_brick_req nxt;
        t_verdict   vd;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                vd.req  = '{i_brick_level, i_brick_z, i_brick_y, i_brick_x};
                vd.keep = brick_visible(vd.req);
                verdict_q.insert(verdict_q.size(), vd);
            end
            if (!start || !busy) begin
                if (brick_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = brick_req_q.pop_front();
                    start         <= 1'b1;
                    i_brick_level <= nxt.lvl;
                    i_brick_z     <= nxt.z;
                    i_brick_y     <= nxt.y;
                    i_brick_x     <= nxt.x;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each verdict with the oldest prediction
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_done) begin
            if (verdict_q.size() == 0) begin
                note_error($sformatf("verdict %b with no request outstanding", o_in_frustum));
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                if (o_in_frustum)
                    n_kept++;
                else
                    n_culled++;
                if (o_in_frustum !== want.keep)
                    note_error($sformatf("lvl %0d z %0d y %0d x %0d: in_frustum exp %b got %b",
                                         want.req.lvl, want.req.z, want.req.y, want.req.x,
                                         want.keep, o_in_frustum));
            end
        end
    end

    // Stimulus and end of run
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: all planes zero keep every brick
        push_brick(0, 0, 0, 0);
        push_brick(15, COORD_MAX, COORD_MAX, COORD_MAX);
        push_brick(5, 0, COORD_MAX, 0);
        push_brick(10, COORD_MAX, 0, COORD_MAX);
        wait_idle();

        run_phase(CFG_BOX_FIXED,  0,  130);
        run_phase(CFG_BOX_RAND,   62, 140);
        run_phase(CFG_EXTREME,    37, 90);
        run_phase(CFG_ZERO_CHUNK, 0,  60);
        run_phase(CFG_RANDOM,     62, 140);
        run_phase(CFG_BOX_OPEN,   37, 140);
        run_phase(CFG_BOX_RAND,   0,  140);

        $display("summary: %0d bricks checked under %0d register settings, %0d kept, %0d culled",
                 n_checked, n_settings, n_kept, n_culled);
        $display("summary: %0d verdict errors", n_errors);
        if (n_errors == 0)
            $display("brick_frustum_cull_test: match");
        else
            $display("brick_frustum_cull_test: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIME_LIMIT);
        $display("timeout with %0d requests pending and %0d verdicts outstanding",
                 brick_req_q.size(), verdict_q.size());
        $display("brick_frustum_cull_test: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bfc_pkg.sv
rtl/core/bfc_regs.sv
rtl/core/bfc_bounds.sv
rtl/core/bfc_planes.sv
rtl/core/brick_frustum_cull_test.sv
verif/brick_frustum_cull_test_tb.sv
